FILE: sv/hmac_sha1_salted_engine_defines.svh
// Assertion macros shared by the checker.
`ifndef HMAC_SHA1_SALTED_ENGINE_DEFINES_SVH
`define HMAC_SHA1_SALTED_ENGINE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define HSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: sv/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Types, constants and SHA-1 helpers shared by the HMAC-SHA1 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package hse_pkg;
    localparam logic [7:0]  IPAD_BYTE      = 8'h36;
    localparam logic [7:0]  OPAD_BYTE      = 8'h5C;
    localparam int unsigned PAD_FILL_BYTES = 44;
    localparam logic [2:0]  NUM_KEY_WORDS  = 3'd5;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    typedef logic [31:0] t_word;
    typedef t_word [4:0] t_hash;

    // Entry of the queue between front and back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_item;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        ST_INIT_IN,   // compress inner pad block
        ST_INIT_OUT,  // compress outer pad block
        ST_IDLE,      // waiting for a queued byte
        ST_MSG,       // compressing a full message block
        ST_PAD1,      // first padding block (length did not fit)
        ST_PAD2,      // final inner block
        ST_OUTER,     // outer hash over inner digest
        ST_EMIT       // streaming digest words
    } t_state;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word round_k(input logic [6:0] t);
        if (t < 7'd20)      round_k = 32'h5A827999;
        else if (t < 7'd40) round_k = 32'h6ED9EBA1;
        else if (t < 7'd60) round_k = 32'h8F1BBCDC;
        else                round_k = 32'hCA62C1D6;
    endfunction

    function automatic t_word round_f(input logic [6:0] t, input t_word b,
                                      input t_word c, input t_word d);
        if (t < 7'd20)      round_f = (b & c) | (~b & d);
        else if (t < 7'd40) round_f = b ^ c ^ d;
        else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
        else                round_f = b ^ c ^ d;
    endfunction
endpackage

FILE: sv/hmac_sha1_salted_engine.sv
// ----------------------------------------------------------------------------
// hmac_sha1_salted_engine
// HMAC-SHA1 of a byte stream under a 20-byte key in five config registers.
// ----------------------------------------------------------------------------
// Usage: message bytes arrive on the input channel, one word per handshake
// (i_data_byte, i_byte_valid, i_last). A word with i_last high closes the
// message; with i_byte_valid low it carries no byte, so a lone such word
// yields the HMAC of the empty message. Bytes past MAX_MESSAGE_BYTES are
// dropped. After the closing word the digest leaves on the output channel as
// five 32-bit big-endian words, o_word_index 0 to 4, o_last_word on the last.
// Throughput: one byte per cycle into a four-entry queue while it is not
// full; the back end takes one queued word per cycle while idle and
// compresses each full 64-byte block in the single-round SHA-1 unit. The
// first digest word is offered after two compressions, or three when the
// length does not fit in the last block, once the closing word leaves the
// queue, then one word per cycle while i_ready is high.
// After reset and after any key register write the inner and outer pad
// midstates are recomputed before bytes are consumed; a key write during
// that work forces another pass once it ends. Input words queue meanwhile.
// A stalled receiver holds the back end in the emit state; the queue keeps
// accepting until it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hmac_sha1_salted_engine #(
    parameter int MAX_MESSAGE_BYTES = 125
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic [31:0] r_key [5];
    logic r_mid_ok;
    logic r_key_dirty;  // key changed since the midstate pass began

    hse_pkg::t_item q_item, in_item;
    logic q_valid, q_pop;

    assign in_item = '{data_byte: i_data_byte, byte_valid: i_byte_valid, last: i_last};

    hse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(in_item), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    // Back end state.
    hse_pkg::t_state r_state, n_state;
    hse_pkg::t_hash  r_imid, r_omid, r_chain;
    logic [15:0][31:0] r_buf;
    logic [6:0] r_len;
    logic [2:0] r_widx;

    logic core_start, core_done;
    hse_pkg::t_hash core_chain, core_hash;
    logic [15:0][31:0] core_block;

    hse_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(core_start),
        .i_chain(core_chain), .i_block(core_block),
        .o_done(core_done), .o_hash(core_hash)
    );

    localparam hse_pkg::t_hash IV = {hse_pkg::IV4, hse_pkg::IV3, hse_pkg::IV2,
                                     hse_pkg::IV1, hse_pkg::IV0};

    logic r_pending;  // compression launched, awaiting done
    // A closing word that also completed a block: padding follows that block.
    logic r_close;
    logic take, accept_byte, full_block;
    logic [5:0] pos;
    logic [5:0] mark;  // block position of the 0x80 terminator
    logic [15:0][31:0] pad_blk, fin_blk, out_blk;
    logic [31:0] rep;
    logic [5:0] p;

    assign take = (r_state == hse_pkg::ST_IDLE) && q_valid && r_mid_ok;
    assign q_pop = take;
    assign accept_byte = take && q_item.byte_valid
                       && ({25'b0, r_len} < MAX_MESSAGE_BYTES);
    assign pos = r_len[5:0];
    assign full_block = accept_byte && (pos == 6'd63);
    assign p = r_len[5:0];
    assign mark = accept_byte ? pos + 6'd1 : pos;

    // Pad-key block for midstate computation.
    always_comb begin
        rep = (r_state == hse_pkg::ST_INIT_IN) ? {4{hse_pkg::IPAD_BYTE}}
                                               : {4{hse_pkg::OPAD_BYTE}};
        pad_blk = {16{rep}};
        for (int i = 0; i < 5; i++) begin
            pad_blk[i] = r_key[i] ^ rep;
        end
    end

    // Final inner block: buffer already holds 0x80 and zeros after the data.
    always_comb begin
        fin_blk = (r_state == hse_pkg::ST_PAD2 && p < 6'd56) ? r_buf : '0;
        fin_blk[14] = 32'd0;
        fin_blk[15] = ({25'd0, r_len} + 32'd64) << 3;
    end

    always_comb begin
        out_blk = '0;
        for (int i = 0; i < 5; i++) out_blk[i] = r_chain[i];
        out_blk[5]  = 32'h80000000;
        out_blk[15] = 32'd672;
    end

    always_comb begin
        core_chain = r_chain;
        core_block = r_buf;
        case (r_state)
            hse_pkg::ST_INIT_IN, hse_pkg::ST_INIT_OUT: begin
                core_chain = IV;
                core_block = pad_blk;
            end
            hse_pkg::ST_PAD2:  core_block = fin_blk;
            hse_pkg::ST_OUTER: begin
                core_chain = r_omid;
                core_block = out_blk;
            end
            default: ;
        endcase
    end

    assign core_start = !r_pending && r_state != hse_pkg::ST_IDLE
                     && r_state != hse_pkg::ST_EMIT;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hse_pkg::ST_INIT_IN:  if (core_done) n_state = hse_pkg::ST_INIT_OUT;
            hse_pkg::ST_INIT_OUT: if (core_done) n_state = hse_pkg::ST_IDLE;
            hse_pkg::ST_IDLE: begin
                if (!r_mid_ok) n_state = hse_pkg::ST_INIT_IN;
                else if (full_block) n_state = hse_pkg::ST_MSG;
                else if (take && q_item.last)
                    n_state = (mark >= 6'd56) ? hse_pkg::ST_PAD1 : hse_pkg::ST_PAD2;
            end
            hse_pkg::ST_MSG: begin
                if (core_done) begin
                    n_state = r_close ? hse_pkg::ST_PAD2 : hse_pkg::ST_IDLE;
                end
            end
            hse_pkg::ST_PAD1: if (core_done) n_state = hse_pkg::ST_PAD2;
            hse_pkg::ST_PAD2: if (core_done) n_state = hse_pkg::ST_OUTER;
            hse_pkg::ST_OUTER: if (core_done) n_state = hse_pkg::ST_EMIT;
            hse_pkg::ST_EMIT: if (i_ready && r_widx == 3'd4) n_state = hse_pkg::ST_IDLE;
            default: n_state = hse_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_valid       = (r_state == hse_pkg::ST_EMIT);
        o_digest_word = r_chain[r_widx];
        o_word_index  = r_widx;
        o_last_word   = (r_widx == 3'd4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hse_pkg::ST_INIT_IN;
            r_mid_ok    <= 1'b0;
            r_key_dirty <= 1'b0;
            r_pending   <= 1'b0;
            r_len       <= '0;
            r_widx      <= '0;
            r_close     <= 1'b0;
            for (int i = 0; i < 5; i++) r_key[i] <= '0;
        end else begin
            r_state <= n_state;
            if (core_start) r_pending <= 1'b1;
            if (core_done)  r_pending <= 1'b0;
            if (i_cfg_we && i_cfg_index < hse_pkg::NUM_KEY_WORDS) begin
                r_key[i_cfg_index] <= i_cfg_data;
                r_mid_ok    <= 1'b0;
                r_key_dirty <= 1'b1;
            end else begin
                if (r_state == hse_pkg::ST_INIT_IN && core_start) r_key_dirty <= 1'b0;
                // A key that changed during the pass forces another one.
                if (r_state == hse_pkg::ST_INIT_OUT && core_done) r_mid_ok <= !r_key_dirty;
            end
            if (accept_byte) r_len <= r_len + 7'd1;
            if (full_block) r_close <= q_item.last;
            if (r_state == hse_pkg::ST_EMIT && i_ready) begin
                r_widx <= r_widx + 3'd1;
                if (r_widx == 3'd4) begin
                    r_widx <= '0;
                    r_len  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hse_pkg::ST_INIT_IN && core_done) r_imid <= core_hash;
        if (r_state == hse_pkg::ST_INIT_OUT && core_done) r_omid <= core_hash;
        if (r_state == hse_pkg::ST_IDLE && r_len == 7'd0 && r_mid_ok)
            r_chain <= r_imid;
        if (core_done && (r_state == hse_pkg::ST_MSG || r_state == hse_pkg::ST_PAD1
                          || r_state == hse_pkg::ST_PAD2 || r_state == hse_pkg::ST_OUTER))
            r_chain <= core_hash;
        if (accept_byte) begin
            r_buf[pos[5:2]][(5'd24 - {pos[1:0], 3'b0}) +: 8] <= q_item.data_byte;
        end
        // Terminator and zero fill placed when the message closes; the byte
        // that comes with the closing word sits below the terminator.
        if (take && q_item.last && !full_block) begin
            for (int i = 0; i < 64; i++) begin
                if (i == int'(mark))
                    r_buf[i/4][(24 - 8*(i%4)) +: 8] <= 8'h80;
                else if (i > int'(mark))
                    r_buf[i/4][(24 - 8*(i%4)) +: 8] <= 8'h00;
            end
        end
        // Closing word that completed a block: finish from an empty block.
        if (r_state == hse_pkg::ST_MSG && core_done && r_close) begin
            r_buf <= {{15{32'd0}}, 32'h80000000};
        end
    end
endmodule

FILE: sv/hse_front.sv
// ----------------------------------------------------------------------------
// hse_front
// Input side: accepts message words into a small queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hse_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output hse_pkg::t_item o_q_item
);
    // Four-entry FIFO.
    hse_pkg::t_item r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic push, pop;

    assign o_ready   = (r_cnt != 3'd4);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 3'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule

FILE: sv/hse_core.sv
// ----------------------------------------------------------------------------
// hse_core
// SHA-1 compression unit: one round per cycle, 16-word schedule window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hse_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  hse_pkg::t_hash                i_chain,
    input  logic [15:0][31:0]             i_block,
    output logic                          o_done,
    output hse_pkg::t_hash                o_hash
);
    logic [15:0][31:0] r_w;
    hse_pkg::t_hash    r_h, r_v;
    logic [6:0]        r_t;
    logic              r_busy;
    hse_pkg::t_word    tmp, wn;

    assign wn  = hse_pkg::rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign tmp = hse_pkg::rotl(r_v[0], 5)
               + hse_pkg::round_f(r_t, r_v[1], r_v[2], r_v[3])
               + r_v[4] + hse_pkg::round_k(r_t) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_t    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (r_busy) begin
                r_t <= r_t + 7'd1;
                if (r_t == 7'd79) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_w <= i_block;
            r_h <= i_chain;
            r_v <= i_chain;
        end else if (r_busy) begin
            r_w <= {wn, r_w[15:1]};
            r_v <= {r_v[3], r_v[2], hse_pkg::rotl(r_v[1], 30), r_v[0], tmp};
            if (r_t == 7'd79) begin
                r_h[0] <= r_h[0] + tmp;
                r_h[1] <= r_h[1] + r_v[0];
                r_h[2] <= r_h[2] + hse_pkg::rotl(r_v[1], 30);
                r_h[3] <= r_h[3] + r_v[2];
                r_h[4] <= r_h[4] + r_v[3];
            end
        end
    end

    assign o_hash = r_h;
endmodule

FILE: sv/hse_checker.sv
// ----------------------------------------------------------------------------
// hse_checker
// Port-level checks for the HMAC-SHA1 engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hmac_sha1_salted_engine_defines.svh"
module hse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);
    `HSE_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, o_valid, o_word_index <= 3'd4, "index range")
    `HSE_ASSERT_IMPL(a_last, i_clk, i_rst_n, o_valid, o_last_word == (o_word_index == 3'd4), "last flag")
    `HSE_ASSERT_NEXT(a_seq, i_clk, i_rst_n, o_valid && i_ready && !o_last_word, o_valid && o_word_index == $past(o_word_index) + 3'd1, "word order")
    `HSE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word), "stall hold")
endmodule

bind hmac_sha1_salted_engine hse_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_digest_word(o_digest_word), .o_word_index(o_word_index),
    .o_last_word(o_last_word)
);
